/* sv/mciir_pkg.sv */
// Shared types and constants for the multichannel IIR filter.
// No dependencies; every other file of the filter imports this package.
package mciir_pkg;

    localparam int CHAN_W     = 3;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 28;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int ACC_W      = 60;
    localparam int ROUND_W    = ACC_W - FRAC_W;
    localparam int NUM_COEF   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int MAC_STAGES = 3;

    // Coefficient register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_A3 = 3'd6;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

    localparam logic signed [ACC_W-1:0]   ROUND_BIAS = 60'sd134217728;
    localparam logic signed [ROUND_W-1:0] SAT_MAX    = 32'sd8388607;
    localparam logic signed [ROUND_W-1:0] SAT_MIN    = -32'sd8388608;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Channel and range flag that travel with each beat.
    typedef struct packed {
        logic              in_range;
        logic [CHAN_W-1:0] chan;
    } beat_tag_t;

    // Occupancy of one pipeline stage, used for the same-channel hazard check.
    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] chan;
    } stage_stat_t;

endpackage

/* sv/multichannel_iir_filter.sv */
// Path: input register (stage A), MAC stages B, C and D, then the output register (stage E).
// Throughput: one beat per cycle while any five consecutive beats use distinct channels
// and the output is not stalled; a beat on a channel still in flight waits until the
// earlier one reaches the output register.
// Reset (aresetn, synchronous, active low) empties the pipeline, zeroes all
// channel histories through per-channel valid bits and restores the coefficients.
module multichannel_iir_filter
    import mciir_pkg::*;
#(
    parameter int ORDER    = 2,
    parameter int CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAN_W-1:0]    s_chan_in,
    input  logic [SAMPLE_W-1:0]  s_sample_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAN_W-1:0]    m_chan_out,
    output logic [SAMPLE_W-1:0]  m_sample_out,
    output logic                 m_clipped
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W = IDX_W + CHAN_W + 1;

    coef_t coef_reg [NUM_COEF];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= (i == int'(REG_B0)) ? COEF_ONE : '0;
            end
        end else if (cfg_we) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    coef_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Channel index widened so it can be compared and truncated to the row index.
    function automatic logic [IDX_W-1:0] row_of(input logic [CHAN_W-1:0] ch);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(ch);
        return wide[IDX_W-1:0];
    endfunction

    logic [CMP_W-1:0] s_chan_wide;
    logic             s_in_range;

    assign s_chan_wide = CMP_W'(s_chan_in);
    assign s_in_range  = s_chan_wide < CMP_W'(CHANNELS);

    // History store.
    sample_t    rd_xh [ORDER];
    sample_t    rd_yh [ORDER];
    logic       hist_wr_en;
    logic [IDX_W-1:0] hist_wr_idx;
    sample_t    hist_wr_xh [ORDER];
    sample_t    hist_wr_yh [ORDER];

    mciir_hist #(
        .CHANNELS (CHANNELS),
        .ORDER    (ORDER),
        .IDX_W    (IDX_W)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (row_of(s_chan_in)),
        .rd_xh   (rd_xh),
        .rd_yh   (rd_yh),
        .wr_en   (hist_wr_en),
        .wr_idx  (hist_wr_idx),
        .wr_xh   (hist_wr_xh),
        .wr_yh   (hist_wr_yh)
    );

    // Stage A: input register with the channel's history.
    logic      a_valid_reg;
    beat_tag_t a_tag_reg;
    sample_t   a_x_reg;
    sample_t   a_xh_reg [ORDER];
    sample_t   a_yh_reg [ORDER];
    logic      a_ready;

    logic        mac_in_ready;
    logic        mac_out_valid;
    logic        mac_out_ready;
    beat_tag_t   mac_out_tag;
    sample_t     mac_out_x;
    sample_t     mac_out_xh [ORDER];
    sample_t     mac_out_yh [ORDER];
    acc_t        mac_out_acc;
    stage_stat_t mac_busy [MAC_STAGES];

    // A beat must not read a channel's history while an earlier beat of the
    // same channel has not yet written it back.
    logic hazard;

    always_comb begin
        hazard = a_valid_reg && (a_tag_reg.chan == s_chan_in);
        for (int i = 0; i < MAC_STAGES; i++) begin
            hazard = hazard || (mac_busy[i].valid && (mac_busy[i].chan == s_chan_in));
        end
    end

    assign a_ready = !a_valid_reg || mac_in_ready;
    assign s_ready = a_ready && !hazard;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_valid && !hazard;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_tag_reg <= '{in_range: s_in_range, chan: s_chan_in};
            a_x_reg   <= s_sample_in;
            a_xh_reg  <= rd_xh;
            a_yh_reg  <= rd_yh;
        end
    end

    mciir_mac #(
        .ORDER (ORDER)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef_reg),
        .in_valid  (a_valid_reg),
        .in_ready  (mac_in_ready),
        .in_tag    (a_tag_reg),
        .in_x      (a_x_reg),
        .in_xh     (a_xh_reg),
        .in_yh     (a_yh_reg),
        .out_valid (mac_out_valid),
        .out_ready (mac_out_ready),
        .out_tag   (mac_out_tag),
        .out_x     (mac_out_x),
        .out_xh    (mac_out_xh),
        .out_yh    (mac_out_yh),
        .out_acc   (mac_out_acc),
        .busy      (mac_busy)
    );

    // Stage E: round, saturate and hold the result.
    logic signed [ROUND_W-1:0] y_wide;
    sample_t                   y_sat;
    logic                      y_clip;
    logic                      e_take;

    logic              m_valid_reg;
    logic [CHAN_W-1:0] m_chan_reg;
    sample_t           m_sample_reg;
    logic              m_clipped_reg;

    assign mac_out_ready = !m_valid_reg || m_ready;
    assign e_take        = mac_out_valid && mac_out_ready;

    always_comb begin
        y_wide = $signed(mac_out_acc[ACC_W-1:FRAC_W]);
        if (y_wide > SAT_MAX) begin
            y_sat  = SAMPLE_W'(SAT_MAX);
            y_clip = 1'b1;
        end else if (y_wide < SAT_MIN) begin
            y_sat  = SAMPLE_W'(SAT_MIN);
            y_clip = 1'b1;
        end else begin
            y_sat  = y_wide[SAMPLE_W-1:0];
            y_clip = 1'b0;
        end
    end

    always_comb begin
        hist_wr_en     = e_take && mac_out_tag.in_range;
        hist_wr_idx    = row_of(mac_out_tag.chan);
        hist_wr_xh[0]  = mac_out_x;
        hist_wr_yh[0]  = y_sat;
        for (int k = 1; k < ORDER; k++) begin
            hist_wr_xh[k] = mac_out_xh[k-1];
            hist_wr_yh[k] = mac_out_yh[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (mac_out_ready) begin
            m_valid_reg <= mac_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_take) begin
            m_chan_reg    <= mac_out_tag.chan;
            m_sample_reg  <= mac_out_tag.in_range ? y_sat : '0;
            m_clipped_reg <= mac_out_tag.in_range && y_clip;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chan_out   = m_chan_reg;
    assign m_sample_out = m_sample_reg;
    assign m_clipped    = m_clipped_reg;

endmodule

/* sv/mciir_hist.sv */
// Per-channel input and output delay lines with one valid bit per channel.
// Depends on mciir_pkg.
module mciir_hist
    import mciir_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int ORDER    = 2,
    parameter int IDX_W    = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] rd_idx,
    output sample_t          rd_xh [ORDER],
    output sample_t          rd_yh [ORDER],
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  sample_t          wr_xh [ORDER],
    input  sample_t          wr_yh [ORDER]
);

    sample_t              xh_mem [CHANNELS][ORDER];
    sample_t              yh_mem [CHANNELS][ORDER];
    logic [CHANNELS-1:0]  row_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (wr_en) begin
            row_valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            xh_mem[wr_idx] <= wr_xh;
            yh_mem[wr_idx] <= wr_yh;
        end
    end

    // A channel never written since reset reads as all zero history.
    always_comb begin
        for (int k = 0; k < ORDER; k++) begin
            rd_xh[k] = row_valid_reg[rd_idx] ? xh_mem[rd_idx][k] : '0;
            rd_yh[k] = row_valid_reg[rd_idx] ? yh_mem[rd_idx][k] : '0;
        end
    end

endmodule

/* sv/mciir_mac.sv */
// Three-stage multiply and accumulate pipeline: products, partial sums,
// then the biased total. Depends on mciir_pkg.
module mciir_mac
    import mciir_pkg::*;
#(
    parameter int ORDER = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  coef_t       coef [NUM_COEF],
    input  logic        in_valid,
    output logic        in_ready,
    input  beat_tag_t   in_tag,
    input  sample_t     in_x,
    input  sample_t     in_xh [ORDER],
    input  sample_t     in_yh [ORDER],
    output logic        out_valid,
    input  logic        out_ready,
    output beat_tag_t   out_tag,
    output sample_t     out_x,
    output sample_t     out_xh [ORDER],
    output sample_t     out_yh [ORDER],
    output acc_t        out_acc,
    output stage_stat_t busy [MAC_STAGES]
);

    // Stage B: products.
    logic      b_valid_reg;
    beat_tag_t b_tag_reg;
    sample_t   b_x_reg;
    sample_t   b_xh_reg [ORDER];
    sample_t   b_yh_reg [ORDER];
    prod_t     b_pb0_reg;
    prod_t     b_pb_reg [ORDER];
    prod_t     b_pa_reg [ORDER];

    // Stage C: feedforward and feedback partial sums.
    logic      c_valid_reg;
    beat_tag_t c_tag_reg;
    sample_t   c_x_reg;
    sample_t   c_xh_reg [ORDER];
    sample_t   c_yh_reg [ORDER];
    acc_t      c_ff_reg;
    acc_t      c_fb_reg;
    acc_t      c_ff_next;
    acc_t      c_fb_next;

    // Stage D: total with the rounding bias folded in.
    logic      d_valid_reg;
    beat_tag_t d_tag_reg;
    sample_t   d_x_reg;
    sample_t   d_xh_reg [ORDER];
    sample_t   d_yh_reg [ORDER];
    acc_t      d_acc_reg;

    logic rdy_b;
    logic rdy_c;
    logic rdy_d;

    assign rdy_d    = !d_valid_reg || out_ready;
    assign rdy_c    = !c_valid_reg || rdy_d;
    assign rdy_b    = !b_valid_reg || rdy_c;
    assign in_ready = rdy_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (rdy_b) begin
                b_valid_reg <= in_valid;
            end
            if (rdy_c) begin
                c_valid_reg <= b_valid_reg;
            end
            if (rdy_d) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy_b) begin
            b_tag_reg <= in_tag;
            b_x_reg   <= in_x;
            b_xh_reg  <= in_xh;
            b_yh_reg  <= in_yh;
            b_pb0_reg <= coef[REG_B0] * in_x;
            for (int k = 0; k < ORDER; k++) begin
                b_pb_reg[k] <= coef[int'(REG_B1) + k] * in_xh[k];
                b_pa_reg[k] <= coef[int'(REG_A1) + k] * in_yh[k];
            end
        end
    end

    always_comb begin
        c_ff_next = ACC_W'(b_pb0_reg);
        c_fb_next = '0;
        for (int k = 0; k < ORDER; k++) begin
            c_ff_next = c_ff_next + ACC_W'(b_pb_reg[k]);
            c_fb_next = c_fb_next + ACC_W'(b_pa_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && rdy_c) begin
            c_tag_reg <= b_tag_reg;
            c_x_reg   <= b_x_reg;
            c_xh_reg  <= b_xh_reg;
            c_yh_reg  <= b_yh_reg;
            c_ff_reg  <= c_ff_next;
            c_fb_reg  <= c_fb_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg && rdy_d) begin
            d_tag_reg <= c_tag_reg;
            d_x_reg   <= c_x_reg;
            d_xh_reg  <= c_xh_reg;
            d_yh_reg  <= c_yh_reg;
            d_acc_reg <= c_ff_reg - c_fb_reg + ROUND_BIAS;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_tag   = d_tag_reg;
    assign out_x     = d_x_reg;
    assign out_xh    = d_xh_reg;
    assign out_yh    = d_yh_reg;
    assign out_acc   = d_acc_reg;

    assign busy[0] = '{valid: b_valid_reg, chan: b_tag_reg.chan};
    assign busy[1] = '{valid: c_valid_reg, chan: c_tag_reg.chan};
    assign busy[2] = '{valid: d_valid_reg, chan: d_tag_reg.chan};

endmodule

/* sv/mciir_checker.sv */
// Port-level checks for the multichannel IIR filter, bound to the top level.
// Depends on mciir_pkg and multichannel_iir_filter.
module mciir_checker
    import mciir_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [CHAN_W-1:0]   s_chan_in,
    input logic                m_valid,
    input logic                m_ready,
    input logic [CHAN_W-1:0]   m_chan_out,
    input logic [SAMPLE_W-1:0] m_sample_out,
    input logic                m_clipped
);

    localparam logic [SAMPLE_W-1:0] OUT_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] OUT_MIN = 24'h80_0000;

    // Reset leaves no result beat pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out) && $stable(m_chan_out)
            && $stable(m_clipped))
        else $error("stalled result beat changed");

    // A clipped result sits at one of the two rails.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clipped |-> (m_sample_out == OUT_MAX) || (m_sample_out == OUT_MIN))
        else $error("clipped flag set on a value inside the range");

    // A channel without delay lines gives a zero, unclipped result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (32'(m_chan_out) >= CHANNELS) |-> (m_sample_out == '0) && !m_clipped)
        else $error("nonzero result on a channel without delay lines");

    // Two beats of one channel are never taken in consecutive cycles.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !(s_valid && s_ready && (s_chan_in == $past(s_chan_in))))
        else $error("same channel accepted while its history was in flight");

endmodule

bind multichannel_iir_filter mciir_checker #(.CHANNELS(CHANNELS)) u_mciir_checker (.*);
